@@ src/script_token_scanner_top_macros.svh @@
`ifndef SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH

// Assertion helpers: one clock, one active-low reset, one message per check.
`ifndef SYNTHESIS
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/sts_pkg.sv @@
package sts_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 16;
	localparam int LENGTH_BITS = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [4:0] K_SYMBOL  = 5'd0;
	localparam logic [4:0] K_INT     = 5'd1;
	localparam logic [4:0] K_FLOAT   = 5'd2;
	localparam logic [4:0] K_OP      = 5'd3;
	localparam logic [4:0] K_EOF     = 5'd4;
	localparam logic [4:0] K_NEWLINE = 5'd5;
	localparam logic [4:0] K_LPAREN  = 5'd6;
	localparam logic [4:0] K_RPAREN  = 5'd7;
	localparam logic [4:0] K_LBRACE  = 5'd8;
	localparam logic [4:0] K_RBRACE  = 5'd9;
	localparam logic [4:0] K_ASSIGN  = 5'd10;
	localparam logic [4:0] K_STRING  = 5'd11;
	localparam logic [4:0] K_FUNC    = 5'd12;
	localparam logic [4:0] K_CALL    = 5'd13;
	localparam logic [4:0] K_SEP     = 5'd14;
	localparam logic [4:0] K_BOOL    = 5'd15;
	localparam logic [4:0] K_NULL    = 5'd16;
	localparam logic [4:0] K_RETURN  = 5'd17;
	localparam logic [4:0] K_LOOP    = 5'd18;
	localparam logic [4:0] K_IF      = 5'd19;
	localparam logic [4:0] K_ELSE    = 5'd20;
	localparam logic [4:0] K_SYNTAX  = 5'd21;
	localparam logic [4:0] K_UNTERM  = 5'd22;

	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_DIV = 5'd2;
	localparam logic [4:0] OP_MUL = 5'd3;
	localparam logic [4:0] OP_MOD = 5'd4;
	localparam logic [4:0] OP_LT  = 5'd5;
	localparam logic [4:0] OP_GT  = 5'd6;
	localparam logic [4:0] OP_NOT = 5'd7;
	localparam logic [4:0] OP_AND = 5'd8;
	localparam logic [4:0] OP_OR  = 5'd9;
	localparam logic [4:0] OP_XOR = 5'd10;
	localparam logic [4:0] OP_INV = 5'd11;
	localparam logic [4:0] OP_LE  = 5'd12;
	localparam logic [4:0] OP_GE  = 5'd13;
	localparam logic [4:0] OP_EQ  = 5'd14;
	localparam logic [4:0] OP_LAND = 5'd15;
	localparam logic [4:0] OP_LOR = 5'd16;
	localparam logic [4:0] OP_NE  = 5'd17;

	localparam int NUM_KW = 7;
	localparam logic [47:0] KW_TEXT [NUM_KW] =
		'{"false", "true", "null", "return", "loop", "if", "else"};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd4, 3'd2, 3'd4};
	localparam logic [4:0] KW_KIND [NUM_KW] =
		'{K_BOOL, K_BOOL, K_NULL, K_RETURN, K_LOOP, K_IF, K_ELSE};

	typedef struct packed {
		logic [4:0]             kind;
		logic [4:0]             op;
		logic [OFFSET_BITS-1:0] offset;
		logic [LINE_BITS-1:0]   line;
		logic [LINE_BITS-1:0]   column;
		logic [LENGTH_BITS-1:0] length;
		logic                   last;
	} tok_t;

	// Character j of keyword i, counted from its first letter.
	function automatic logic [7:0] kw_char(input int i, input logic [2:0] j);
		logic [5:0]  sh;
		logic [47:0] w;
		sh = {KW_LEN[i] - 3'd1 - j, 3'b000};
		w  = KW_TEXT[i] >> sh;
		return w[7:0];
	endfunction

	function automatic logic [NUM_KW-1:0] kw_next(input logic [NUM_KW-1:0] cand,
			input logic [LENGTH_BITS-1:0] len, input logic [7:0] c);
		logic [NUM_KW-1:0] r;
		r = '0;
		for (int i = 0; i < NUM_KW; i++)
			r[i] = cand[i] && (len < LENGTH_BITS'(KW_LEN[i])) && (kw_char(i, len[2:0]) == c);
		return r;
	endfunction

	function automatic logic [4:0] word_kind(input logic [NUM_KW-1:0] cand,
			input logic [LENGTH_BITS-1:0] len);
		logic [4:0] k;
		k = K_SYMBOL;
		for (int i = NUM_KW - 1; i >= 0; i--)
			if (cand[i] && len == LENGTH_BITS'(KW_LEN[i]))
				k = KW_KIND[i];
		return k;
	endfunction

endpackage

@@ src/sts_front.sv @@
`include "script_token_scanner_top_macros.svh"

module sts_front import sts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] char_byte,
	output logic       v0,
	output logic       v1,
	output tok_t       tok0,
	output tok_t       tok1
);

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_INT, M_FLOAT, M_STR, M_HASH, M_QUEST,
		M_LT, M_GT, M_EQ, M_AMP, M_BAR, M_BANG, M_HALT
	} mode_t;

	mode_t                  mode_q, nm;
	logic [NUM_KW-1:0]      kw_q, kwn;
	logic [OFFSET_BITS-1:0] off_q, st_off_q;
	logic [LINE_BITS-1:0]   line_q, col_q, st_line_q, st_col_q;
	logic [LENGTH_BITS-1:0] len_q, len_n;
	logic                   adv, fall, latch;
	logic                   e0v, env;
	logic [4:0]             e0k, e0o, enk, eno;
	logic [LENGTH_BITS-1:0] e0l, enl;
	logic [LENGTH_BITS-1:0] len_inc;
	logic [7:0]             c;
	logic                   is_alpha, is_digit;

	assign c        = char_byte;
	assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	assign is_digit = c >= "0" && c <= "9";
	assign len_inc  = (len_q == '1) ? len_q : len_q + 1'b1;

	always_comb begin
		nm    = mode_q;
		kwn   = kw_q;
		len_n = len_q;
		adv   = 1'b0;
		fall  = 1'b0;
		latch = 1'b0;
		e0v   = 1'b0;
		e0k   = K_SYMBOL;
		e0o   = OP_ADD;
		e0l   = '0;
		env   = 1'b0;
		enk   = K_SYMBOL;
		eno   = OP_ADD;
		enl   = '0;
		unique case (mode_q)
			M_HALT: ;
			M_IDENT: begin
				if (is_alpha || is_digit) begin
					kwn   = kw_next(kw_q, len_q, c);
					len_n = len_inc;
					adv   = 1'b1;
				end else begin
					e0v  = 1'b1;
					e0k  = word_kind(kw_q, len_q);
					e0l  = len_q;
					fall = 1'b1;
				end
			end
			M_INT, M_FLOAT: begin
				if (is_digit || (c == "." && mode_q == M_INT)) begin
					if (c == ".") nm = M_FLOAT;
					len_n = len_inc;
					adv   = 1'b1;
				end else begin
					e0v  = 1'b1;
					e0k  = (mode_q == M_FLOAT) ? K_FLOAT : K_INT;
					e0l  = len_q;
					fall = 1'b1;
				end
			end
			M_STR: begin
				if (c == "\"") begin
					e0v = 1'b1; e0k = K_STRING; e0l = len_q;
					adv = 1'b1; nm = M_IDLE;
				end else if (c == 8'd0) begin
					e0v = 1'b1; e0k = K_UNTERM; e0l = len_q;
					nm  = M_HALT;
				end else begin
					len_n = len_inc;
					adv   = 1'b1;
				end
			end
			M_HASH: begin
				if (c != "\n" && c != 8'd0) adv = 1'b1;
				else fall = 1'b1;
			end
			M_QUEST: begin
				if (c == 8'd0) begin
					e0v = 1'b1; e0k = K_UNTERM;
					nm  = M_HALT;
				end else begin
					if (c == "?") nm = M_IDLE;
					adv = 1'b1;
				end
			end
			M_LT, M_GT, M_EQ, M_AMP, M_BAR, M_BANG: begin
				if (mode_q == M_LT && c == "-") begin
					e0v = 1'b1; e0k = K_ASSIGN; e0l = LENGTH_BITS'(2);
					adv = 1'b1; nm = M_IDLE;
				end else if ((mode_q == M_AMP && c == "&") || (mode_q == M_BAR && c == "|") ||
						(mode_q != M_AMP && mode_q != M_BAR && c == "=")) begin
					e0v = 1'b1; e0k = K_OP; e0l = LENGTH_BITS'(2);
					case (mode_q)
						M_LT:    e0o = OP_LE;
						M_GT:    e0o = OP_GE;
						M_EQ:    e0o = OP_EQ;
						M_AMP:   e0o = OP_LAND;
						M_BAR:   e0o = OP_LOR;
						default: e0o = OP_NE;
					endcase
					adv = 1'b1; nm = M_IDLE;
				end else if (mode_q == M_EQ) begin
					e0v = 1'b1; e0k = K_SYNTAX;
					nm  = M_HALT;
				end else begin
					e0v = 1'b1; e0k = K_OP; e0l = LENGTH_BITS'(1);
					case (mode_q)
						M_LT:    e0o = OP_LT;
						M_GT:    e0o = OP_GT;
						M_BANG:  e0o = OP_NOT;
						M_AMP:   e0o = OP_AND;
						default: e0o = OP_OR;
					endcase
					fall = 1'b1;
				end
			end
			default: fall = 1'b1;
		endcase

		// The byte did not extend the pending token, so it opens a new one.
		if (fall) begin
			latch = 1'b1;
			nm    = M_IDLE;
			len_n = '0;
			if (is_alpha) begin
				kwn   = kw_next('1, '0, c);
				len_n = LENGTH_BITS'(1);
				nm    = M_IDENT;
				adv   = 1'b1;
			end else if (is_digit) begin
				len_n = LENGTH_BITS'(1);
				nm    = M_INT;
				adv   = 1'b1;
			end else begin
				env = 1'b1;
				case (c)
					"\"":   begin env = 1'b0; nm = M_STR; end
					"<":    begin env = 1'b0; nm = M_LT; end
					">":    begin env = 1'b0; nm = M_GT; end
					"=":    begin env = 1'b0; nm = M_EQ; end
					"&":    begin env = 1'b0; nm = M_AMP; end
					"|":    begin env = 1'b0; nm = M_BAR; end
					"!":    begin env = 1'b0; nm = M_BANG; end
					"#":    begin env = 1'b0; nm = M_HASH; end
					"?":    begin env = 1'b0; nm = M_QUEST; end
					" ", 8'h0D, "\t": env = 1'b0;
					8'd0:   enk = K_EOF;
					"\n":   enk = K_NEWLINE;
					"(":    enk = K_LPAREN;
					")":    enk = K_RPAREN;
					"{":    enk = K_LBRACE;
					"}":    enk = K_RBRACE;
					"$":    enk = K_FUNC;
					"@":    enk = K_CALL;
					",":    enk = K_SEP;
					"+":    begin enk = K_OP; eno = OP_ADD; enl = LENGTH_BITS'(1); end
					"-":    begin enk = K_OP; eno = OP_SUB; enl = LENGTH_BITS'(1); end
					"/":    begin enk = K_OP; eno = OP_DIV; enl = LENGTH_BITS'(1); end
					"*":    begin enk = K_OP; eno = OP_MUL; enl = LENGTH_BITS'(1); end
					"%":    begin enk = K_OP; eno = OP_MOD; enl = LENGTH_BITS'(1); end
					"^":    begin enk = K_OP; eno = OP_XOR; enl = LENGTH_BITS'(1); end
					"~":    begin enk = K_OP; eno = OP_INV; enl = LENGTH_BITS'(1); end
					default: enk = K_SYNTAX;
				endcase
				if (env && (enk == K_EOF || enk == K_SYNTAX)) nm = M_HALT;
				else adv = 1'b1;
			end
		end
	end

	// The pending token goes out first; a token opened by the same byte follows it.
	always_comb begin
		tok0 = '{kind: e0k, op: e0o, offset: st_off_q, line: st_line_q, column: st_col_q,
			length: e0l, last: 1'b0};
		tok1 = '{kind: enk, op: eno, offset: off_q, line: line_q, column: col_q,
			length: enl, last: 1'b1};
		v0   = take && (e0v || env);
		v1   = take && e0v && env;
		if (!e0v) tok0 = tok1;
		else tok0.last = !env;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			kw_q      <= '0;
			off_q     <= '0;
			line_q    <= '0;
			col_q     <= '0;
			st_off_q  <= '0;
			st_line_q <= '0;
			st_col_q  <= '0;
			len_q     <= '0;
		end else if (take) begin
			mode_q <= nm;
			kw_q   <= kwn;
			len_q  <= len_n;
			if (latch) begin
				st_off_q  <= off_q;
				st_line_q <= line_q;
				st_col_q  <= col_q;
			end
			if (adv) begin
				if (off_q != '1) off_q <= off_q + 1'b1;
				if (c == "\n") begin
					col_q <= '0;
					if (line_q != '1) line_q <= line_q + 1'b1;
				end else if (col_q != '1) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	`STS_ASSERT_NEXT(a_halt_sticks, clk, arst_n, mode_q == M_HALT, mode_q == M_HALT, "scanner left halt")
	`STS_ASSERT_IMPL(a_second_needs_first, clk, arst_n, v1, v0, "second beat without first")

endmodule

@@ src/sts_queue.sv @@
`include "script_token_scanner_top_macros.svh"

module sts_queue import sts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic v0,
	input  logic v1,
	input  tok_t tok0,
	input  tok_t tok1,
	output logic full,
	output logic empty,
	input  logic pop,
	output tok_t head
);

	tok_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wp_q, rp_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 deq;

	// Room for the two beats one byte can cause is kept free.
	assign full  = cnt_q > QCNT_BITS'(QUEUE_DEPTH - 2);
	assign empty = cnt_q == '0;
	assign deq   = pop && !empty;
	assign head  = mem[rp_q];

	always_ff @(posedge clk) begin
		if (v0) mem[wp_q] <= tok0;
		if (v1) mem[wp_q + 1'b1] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_BITS'(v0) + QPTR_BITS'(v1);
			rp_q  <= rp_q + QPTR_BITS'(deq);
			cnt_q <= cnt_q + QCNT_BITS'(v0) + QCNT_BITS'(v1) - QCNT_BITS'(deq);
		end
	end

	`STS_ASSERT_IMPL(a_no_overflow, clk, arst_n, 1'b1, cnt_q <= QCNT_BITS'(QUEUE_DEPTH), "queue overflow")
	`STS_ASSERT_IMPL(a_push_has_room, clk, arst_n, v0, !full, "beat written into full queue")

endmodule

@@ src/script_token_scanner_top.sv @@
// Channel  | Direction | Handshake        | Beat
// input    | in        | push / full      | char_byte
// result   | out       | pop / empty      | token_kind .. last_of_run
//
// One byte is taken every cycle while push is high and full is low; it causes zero, one or two result beats.
// The scanner state is registered; a four-entry token queue holds results.
// full rises once fewer than two entries are free, so a stalled reader stalls input.
// arst_n clears the scanner position and the queue; no clearing pass is needed.
// After end of input or an error the scanner halts and drops bytes until reset.
module script_token_scanner_top import sts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             char_byte,
	output logic                   empty,
	input  logic                   pop,
	output logic [4:0]             token_kind,
	output logic [4:0]             operator_code,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [LINE_BITS-1:0]   start_line,
	output logic [LINE_BITS-1:0]   start_column,
	output logic [LENGTH_BITS-1:0] text_length,
	output logic                   last_of_run
);

	logic v0, v1;
	tok_t tok0, tok1, head;

	sts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (push && !full),
		.char_byte (char_byte),
		.v0        (v0),
		.v1        (v1),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	sts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.v0     (v0),
		.v1     (v1),
		.tok0   (tok0),
		.tok1   (tok1),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign token_kind    = head.kind;
	assign operator_code = head.op;
	assign start_offset  = head.offset;
	assign start_line    = head.line;
	assign start_column  = head.column;
	assign text_length   = head.length;
	assign last_of_run   = head.last;

endmodule
